[src/fzc_pkg.sv]
package fzc_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int FRAC_BITS   = 8;
  localparam int LEVEL_BITS  = 8;
  localparam int SPEED_BITS  = 16;

  // Membership breakpoints in sample counts
  localparam int EDGE_A = 300;
  localparam int EDGE_B = 400;
  localparam int EDGE_C = 500;
  localparam int EDGE_D = 600;
  localparam int SPAN   = 100;

  // x*2^F/100 as (x*RECIP) >> (RECIP_SHIFT-F); exact for x <= 100, F <= 12
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP       = (2**RECIP_SHIFT + SPAN - 1) / SPAN;
  localparam int RECIP_BITS  = 22;
  localparam int OFS_BITS    = 7;

  // Fuzzifier segment codes
  localparam logic [2:0] SEG_LOW  = 3'd0;
  localparam logic [2:0] SEG_RISE = 3'd1;
  localparam logic [2:0] SEG_MED  = 3'd2;
  localparam logic [2:0] SEG_FALL = 3'd3;
  localparam logic [2:0] SEG_HIGH = 3'd4;

  // Rule conclusion codes
  localparam logic [1:0] CONC_LOW  = 2'd0;
  localparam logic [1:0] CONC_MED  = 2'd1;
  localparam logic [1:0] CONC_HIGH = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_LOW_SPEED  = 2'd0;
  localparam logic [1:0] REG_MID_SPEED  = 2'd1;
  localparam logic [1:0] REG_HIGH_SPEED = 2'd2;

  localparam logic [LEVEL_BITS-1:0] LOW_SPEED_RST  = 8'd30;
  localparam logic [LEVEL_BITS-1:0] MID_SPEED_RST  = 8'd50;
  localparam logic [LEVEL_BITS-1:0] HIGH_SPEED_RST = 8'd70;

  localparam logic [1:0] WALL_LEFT [9] = '{
    CONC_LOW, CONC_LOW, CONC_MED, CONC_MED, CONC_MED, CONC_MED,
    CONC_MED, CONC_HIGH, CONC_MED};
  localparam logic [1:0] WALL_RIGHT [9] = '{
    CONC_HIGH, CONC_MED, CONC_MED, CONC_LOW, CONC_MED, CONC_MED,
    CONC_LOW, CONC_MED, CONC_MED};
  localparam logic [1:0] OBST_LEFT [27] = '{
    CONC_MED, CONC_LOW, CONC_LOW,  CONC_LOW, CONC_LOW, CONC_HIGH,
    CONC_LOW, CONC_LOW, CONC_LOW,
    CONC_LOW, CONC_LOW, CONC_HIGH, CONC_LOW, CONC_MED, CONC_HIGH,
    CONC_MED, CONC_MED, CONC_MED,
    CONC_MED, CONC_MED, CONC_MED,  CONC_MED, CONC_LOW, CONC_MED,
    CONC_MED, CONC_MED, CONC_MED};
  localparam logic [1:0] OBST_RIGHT [27] = '{
    CONC_LOW, CONC_HIGH, CONC_HIGH, CONC_LOW, CONC_LOW, CONC_LOW,
    CONC_LOW, CONC_LOW, CONC_LOW,
    CONC_HIGH, CONC_HIGH, CONC_LOW, CONC_LOW, CONC_LOW, CONC_LOW,
    CONC_MED, CONC_MED, CONC_MED,
    CONC_HIGH, CONC_HIGH, CONC_HIGH, CONC_MED, CONC_MED, CONC_HIGH,
    CONC_HIGH, CONC_HIGH, CONC_MED};

endpackage

[src/fzc_fuzzify.sv]
module fzc_fuzzify #(
  parameter int SB = fzc_pkg::SAMPLE_BITS,
  parameter int F  = fzc_pkg::FRAC_BITS
) (
  input  logic          clk,
  input  logic          en,
  input  logic [SB-1:0] dist_in,
  output logic [F:0]    m_low,
  output logic [F:0]    m_med,
  output logic [F:0]    m_high
);

  localparam int OW = fzc_pkg::OFS_BITS;
  localparam int PW = OW + fzc_pkg::RECIP_BITS;
  localparam int SH = fzc_pkg::RECIP_SHIFT - F;
  localparam logic [F:0] ONE = (F+1)'(1) << F;

  logic [2:0]    seg;
  logic [OW-1:0] ofs;
  logic [2:0]    seg_next;
  logic [OW-1:0] ofs_next;
  logic [PW-1:0] prod_up;
  logic [PW-1:0] prod_dn;
  logic [F:0]    frac_up;
  logic [F:0]    frac_dn;

  // Stage 1: locate the segment and the offset into it
  always_comb begin
    seg_next = fzc_pkg::SEG_HIGH;
    ofs_next = '0;
    priority if (dist_in <= SB'(fzc_pkg::EDGE_A)) begin
      seg_next = fzc_pkg::SEG_LOW;
    end else if (dist_in <= SB'(fzc_pkg::EDGE_B)) begin
      seg_next = fzc_pkg::SEG_RISE;
      ofs_next = OW'(dist_in - SB'(fzc_pkg::EDGE_A));
    end else if (dist_in <= SB'(fzc_pkg::EDGE_C)) begin
      seg_next = fzc_pkg::SEG_MED;
    end else if (dist_in <= SB'(fzc_pkg::EDGE_D)) begin
      seg_next = fzc_pkg::SEG_FALL;
      ofs_next = OW'(dist_in - SB'(fzc_pkg::EDGE_C));
    end else begin
      seg_next = fzc_pkg::SEG_HIGH;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg <= seg_next;
      ofs <= ofs_next;
    end
  end

  // Stage 2: ramp values by reciprocal multiply
  always_comb begin
    prod_up = PW'(ofs) * PW'(fzc_pkg::RECIP);
    prod_dn = PW'(OW'(fzc_pkg::SPAN) - ofs) * PW'(fzc_pkg::RECIP);
    frac_up = (F+1)'(prod_up >> SH);
    frac_dn = (F+1)'(prod_dn >> SH);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_low  <= '0;
      m_med  <= '0;
      m_high <= '0;
      unique case (seg)
        fzc_pkg::SEG_LOW: m_low <= ONE;
        fzc_pkg::SEG_RISE: begin
          m_low <= frac_dn;
          m_med <= frac_up;
        end
        fzc_pkg::SEG_MED: m_med <= ONE;
        fzc_pkg::SEG_FALL: begin
          m_med  <= frac_dn;
          m_high <= frac_up;
        end
        default: m_high <= ONE;
      endcase
    end
  end

endmodule

[src/fzc_rules.sv]
module fzc_rules #(
  parameter int F = fzc_pkg::FRAC_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic           in_wall,
  input  logic [F:0]     m1 [3],
  input  logic [F:0]     m2 [3],
  input  logic [F:0]     m3 [3],
  input  logic [7:0]     low_speed,
  input  logic [7:0]     mid_speed,
  input  logic [7:0]     high_speed,
  output logic           out_valid,
  output logic           out_wall,
  output logic [F+12:0]  num_left,
  output logic [F+12:0]  num_right,
  output logic [F+4:0]   den
);

  localparam int MW = F + 1;
  localparam int DW = F + 5;
  localparam int NW = DW + 8;

  logic [MW-1:0] str [27];
  logic [1:0]    cls_l [27];
  logic [1:0]    cls_r [27];
  logic          v3, v4, v5;
  logic          w3, w4, w5;
  logic [DW-1:0] grp_l [3][3];
  logic [DW-1:0] grp_r [3][3];
  logic [DW-1:0] grp_d [3];
  logic [DW-1:0] tot_l [3];
  logic [DW-1:0] tot_r [3];
  logic [DW-1:0] tot_d;

  // Stage 3: rule strengths and conclusions
  for (genvar r = 0; r < 27; r++) begin : g_rule
    localparam int I = r / 9;
    localparam int J = (r / 3) % 3;
    localparam int K = r % 3;
    logic [MW-1:0] s_ob;
    logic [MW-1:0] s_w;
    logic [MW-1:0] a_ij;
    assign a_ij = (m1[I] < m2[J]) ? m1[I] : m2[J];
    assign s_ob = (a_ij < m3[K]) ? a_ij : m3[K];
    if (r < 9) begin : g_wall
      localparam int WI = r / 3;
      localparam int WJ = r % 3;
      assign s_w = (m1[WI] < m2[WJ]) ? m1[WI] : m2[WJ];
    end else begin : g_nowall
      assign s_w = '0;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        str[r] <= in_wall ? s_w : s_ob;
        if (r < 9) begin
          cls_l[r] <= in_wall ? fzc_pkg::WALL_LEFT[r % 9] : fzc_pkg::OBST_LEFT[r];
          cls_r[r] <= in_wall ? fzc_pkg::WALL_RIGHT[r % 9] : fzc_pkg::OBST_RIGHT[r];
        end else begin
          cls_l[r] <= fzc_pkg::OBST_LEFT[r];
          cls_r[r] <= fzc_pkg::OBST_RIGHT[r];
        end
      end
    end
  end

  // Stage 4: per-class sums over groups of nine rules
  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < 3; g++) begin
        logic [DW-1:0] al [3];
        logic [DW-1:0] ar [3];
        logic [DW-1:0] ad;
        for (int c = 0; c < 3; c++) begin
          al[c] = '0;
          ar[c] = '0;
        end
        ad = '0;
        for (int n = 0; n < 9; n++) begin
          ad = ad + DW'(str[g*9+n]);
          for (int c = 0; c < 3; c++) begin
            if (cls_l[g*9+n] == 2'(c)) al[c] = al[c] + DW'(str[g*9+n]);
            if (cls_r[g*9+n] == 2'(c)) ar[c] = ar[c] + DW'(str[g*9+n]);
          end
        end
        for (int c = 0; c < 3; c++) begin
          grp_l[g][c] <= al[c];
          grp_r[g][c] <= ar[c];
        end
        grp_d[g] <= ad;
      end
    end
  end

  // Stage 5: totals
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        tot_l[c] <= grp_l[0][c] + grp_l[1][c] + grp_l[2][c];
        tot_r[c] <= grp_r[0][c] + grp_r[1][c] + grp_r[2][c];
      end
      tot_d <= grp_d[0] + grp_d[1] + grp_d[2];
    end
  end

  // Stage 6: weight class sums by speed levels
  always_ff @(posedge clk) begin
    if (en) begin
      num_left  <= NW'(tot_l[fzc_pkg::CONC_LOW] * NW'(low_speed)
                 + tot_l[fzc_pkg::CONC_MED] * NW'(mid_speed)
                 + tot_l[fzc_pkg::CONC_HIGH] * NW'(high_speed));
      num_right <= NW'(tot_r[fzc_pkg::CONC_LOW] * NW'(low_speed)
                 + tot_r[fzc_pkg::CONC_MED] * NW'(mid_speed)
                 + tot_r[fzc_pkg::CONC_HIGH] * NW'(high_speed));
      den       <= tot_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v3 <= in_valid;
      v4 <= v3;
      v5 <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w3 <= in_wall;
      w4 <= w3;
      w5 <= w4;
      out_wall <= w5;
    end
  end

endmodule

[src/fzc_divider.sv]
module fzc_divider #(
  parameter int F = fzc_pkg::FRAC_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic          in_wall,
  input  logic [F+12:0] num_left,
  input  logic [F+12:0] num_right,
  input  logic [F+4:0]  den_in,
  output logic          out_valid,
  output logic          out_wall,
  output logic [15:0]   left_speed,
  output logic [15:0]   right_speed
);

  localparam int DW = F + 5;
  localparam int QB = F + 8;

  logic          v   [QB];
  logic          w   [QB];
  logic          zr  [QB];
  logic [DW-1:0] dn  [QB];
  logic [7:0]    lol [QB];
  logic [7:0]    lor [QB];
  logic [DW-1:0] rl  [QB];
  logic [DW-1:0] rr  [QB];
  logic [QB-1:0] ql  [QB];
  logic [QB-1:0] qr  [QB];

  // One quotient bit per stage, both motors share the divisor
  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int BI = QB - 1 - k;
    logic          pv, pw, pz;
    logic [DW-1:0] pd, prl, prr;
    logic [7:0]    plol, plor;
    logic [QB-1:0] pql, pqr;
    logic          bl, br, gel, ger;
    logic [DW:0]   tl, tr;
    if (k == 0) begin : g_first
      assign pv   = in_valid;
      assign pw   = in_wall;
      assign pz   = (den_in == '0);
      assign pd   = den_in;
      assign plol = num_left[7:0];
      assign plor = num_right[7:0];
      assign prl  = num_left[F+12:8];
      assign prr  = num_right[F+12:8];
      assign pql  = '0;
      assign pqr  = '0;
    end else begin : g_next
      assign pv   = v[k-1];
      assign pw   = w[k-1];
      assign pz   = zr[k-1];
      assign pd   = dn[k-1];
      assign plol = lol[k-1];
      assign plor = lor[k-1];
      assign prl  = rl[k-1];
      assign prr  = rr[k-1];
      assign pql  = ql[k-1];
      assign pqr  = qr[k-1];
    end
    if (BI >= F) begin : g_bit
      assign bl = plol[BI-F];
      assign br = plor[BI-F];
    end else begin : g_zero
      assign bl = 1'b0;
      assign br = 1'b0;
    end
    assign tl  = {prl, bl};
    assign tr  = {prr, br};
    assign gel = tl >= {1'b0, pd};
    assign ger = tr >= {1'b0, pd};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        w[k]   <= pw;
        zr[k]  <= pz;
        dn[k]  <= pd;
        lol[k] <= plol;
        lor[k] <= plor;
        rl[k]  <= gel ? DW'(tl - {1'b0, pd}) : tl[DW-1:0];
        rr[k]  <= ger ? DW'(tr - {1'b0, pd}) : tr[DW-1:0];
        ql[k]  <= {pql[QB-2:0], gel};
        qr[k]  <= {pqr[QB-2:0], ger};
      end
    end
  end

  logic [QB+15:0] qxl, qxr;
  assign qxl = {16'b0, ql[QB-1]};
  assign qxr = {16'b0, qr[QB-1]};

  assign out_valid   = v[QB-1];
  assign out_wall    = w[QB-1];
  assign left_speed  = zr[QB-1] ? 16'd0 : (|qxl[QB+15:16] ? 16'hFFFF : qxl[15:0]);
  assign right_speed = zr[QB-1] ? 16'd0 : (|qxr[QB+15:16] ? 16'hFFFF : qxr[15:0]);

endmodule

[src/fuzzy_two_motor_speed_controller.sv]
// Two-motor fuzzy speed controller. Each input item carries three distance
// samples; each is fuzzified into low/medium/high memberships (FRAC_BITS
// fraction bits), then either the 9-rule wall-follow base (dist_three > 500
// and dist_two < 500) or the 27-rule obstacle base is fired, rule strength
// being the minimum of its memberships. Each motor speed is the strength-
// weighted average of the low/mid/high speed levels, with FRAC_BITS fraction
// bits, truncated and saturated to 16 bits; avoid_mode on tuser tells which
// base was used. The block is fully pipelined: one item is accepted every
// cycle while the output is not stalled. The restoring divider resolves one
// quotient bit per stage. A stall on the output freezes the whole pipeline;
// no item is lost. Speed levels are written through the cfg port; the user
// must write them only while the pipeline is empty, which the block itself
// does not enforce.
module fuzzy_two_motor_speed_controller #(
  parameter int SAMPLE_BITS = fzc_pkg::SAMPLE_BITS,
  parameter int FRAC_BITS   = fzc_pkg::FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  // dist_one, dist_two, dist_three, then zero fill
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
  // left_speed [15:0], right_speed [31:16]
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [31:0]                           m_tdata,
  // avoid_mode
  output logic                                  m_tuser,
  input  logic                                  cfg_we,
  input  logic [1:0]                            cfg_index,
  input  logic [7:0]                            cfg_data
);

  localparam int SB = SAMPLE_BITS;
  localparam int F  = FRAC_BITS;

  logic [7:0]    low_speed, mid_speed, high_speed;
  logic          en;
  logic          v1, v2, w1, w2;
  logic [F:0]    m1 [3];
  logic [F:0]    m2 [3];
  logic [F:0]    m3 [3];
  logic [SB-1:0] d2, d3;
  logic          rv, rw;
  logic [F+12:0] nl, nr;
  logic [F+4:0]  den;
  logic [15:0]   left_speed, right_speed;
  logic          wall_out;

  // Advance every stage together unless the output item is held
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign d2 = s_tdata[2*SB-1:SB];
  assign d3 = s_tdata[3*SB-1:2*SB];

  always_ff @(posedge clk) begin
    if (rst) begin
      low_speed  <= fzc_pkg::LOW_SPEED_RST;
      mid_speed  <= fzc_pkg::MID_SPEED_RST;
      high_speed <= fzc_pkg::HIGH_SPEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fzc_pkg::REG_LOW_SPEED:  low_speed  <= cfg_data;
        fzc_pkg::REG_MID_SPEED:  mid_speed  <= cfg_data;
        fzc_pkg::REG_HIGH_SPEED: high_speed <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid and rule-base choice alongside the two fuzzifier stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1 <= (d3 > SB'(fzc_pkg::EDGE_C)) && (d2 < SB'(fzc_pkg::EDGE_C));
      w2 <= w1;
    end
  end

  fzc_fuzzify #(.SB(SB), .F(F)) u_fz1 (
    .clk(clk), .en(en), .dist_in(s_tdata[SB-1:0]),
    .m_low(m1[0]), .m_med(m1[1]), .m_high(m1[2]));
  fzc_fuzzify #(.SB(SB), .F(F)) u_fz2 (
    .clk(clk), .en(en), .dist_in(d2),
    .m_low(m2[0]), .m_med(m2[1]), .m_high(m2[2]));
  fzc_fuzzify #(.SB(SB), .F(F)) u_fz3 (
    .clk(clk), .en(en), .dist_in(d3),
    .m_low(m3[0]), .m_med(m3[1]), .m_high(m3[2]));

  fzc_rules #(.F(F)) u_rules (
    .clk(clk), .rst(rst), .en(en), .in_valid(v2), .in_wall(w2),
    .m1(m1), .m2(m2), .m3(m3),
    .low_speed(low_speed), .mid_speed(mid_speed), .high_speed(high_speed),
    .out_valid(rv), .out_wall(rw), .num_left(nl), .num_right(nr), .den(den));

  fzc_divider #(.F(F)) u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(rv), .in_wall(rw),
    .num_left(nl), .num_right(nr), .den_in(den),
    .out_valid(m_tvalid), .out_wall(wall_out),
    .left_speed(left_speed), .right_speed(right_speed));

  assign m_tdata = {right_speed, left_speed};
  assign m_tuser = !wall_out;

endmodule

[sim/speed_checker.sv]
module speed_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        m_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [15:0] left_speed;
    logic [15:0] right_speed;
    logic        avoid_mode;
  } speed_t;

  speed_t speed_q[$];
  logic [7:0] lvl_low, lvl_mid, lvl_high;

  assign pending = speed_q.size();

  function automatic void membership(input int d, output int m[3]);
    int one;
    one = 1 << fzc_pkg::FRAC_BITS;
    m = '{0, 0, 0};
    if (d <= fzc_pkg::EDGE_A) m[0] = one;
    else if (d <= fzc_pkg::EDGE_B) begin
      m[0] = ((fzc_pkg::EDGE_B - d) * one) / fzc_pkg::SPAN;
      m[1] = ((d - fzc_pkg::EDGE_A) * one) / fzc_pkg::SPAN;
    end else if (d <= fzc_pkg::EDGE_C) m[1] = one;
    else if (d <= fzc_pkg::EDGE_D) begin
      m[1] = ((fzc_pkg::EDGE_D - d) * one) / fzc_pkg::SPAN;
      m[2] = ((d - fzc_pkg::EDGE_C) * one) / fzc_pkg::SPAN;
    end else m[2] = one;
  endfunction

  function automatic longint level(input logic [1:0] c);
    case (c)
      fzc_pkg::CONC_LOW: return lvl_low;
      fzc_pkg::CONC_MED: return lvl_mid;
      default:  return lvl_high;
    endcase
  endfunction

  function automatic logic [15:0] quotient(input longint num, input longint den);
    longint q;
    if (den == 0) return 16'd0;
    q = (num << fzc_pkg::FRAC_BITS) / den;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic speed_t predict_speed(input logic [39:0] data);
    int m1[3], m2[3], m3[3];
    int s;
    longint nl, nr, den;
    logic wall;
    speed_t r;
    membership(data[11:0], m1);
    membership(data[23:12], m2);
    membership(data[35:24], m3);
    nl = 0; nr = 0; den = 0;
    wall = (data[35:24] > fzc_pkg::EDGE_C) && (data[23:12] < fzc_pkg::EDGE_C);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        if (wall) begin
          s = (m1[i] < m2[j]) ? m1[i] : m2[j];
          nl += s * level(fzc_pkg::WALL_LEFT[i*3+j]);
          nr += s * level(fzc_pkg::WALL_RIGHT[i*3+j]);
          den += s;
        end else
          for (int k = 0; k < 3; k++) begin
            s = (m1[i] < m2[j]) ? m1[i] : m2[j];
            s = (s < m3[k]) ? s : m3[k];
            nl += s * level(fzc_pkg::OBST_LEFT[i*9+j*3+k]);
            nr += s * level(fzc_pkg::OBST_RIGHT[i*9+j*3+k]);
            den += s;
          end
    r.left_speed = quotient(nl, den);
    r.right_speed = quotient(nr, den);
    r.avoid_mode = !wall;
    return r;
  endfunction

  always @(posedge clk) begin
    speed_t want;
    if (rst) begin
      lvl_low <= fzc_pkg::LOW_SPEED_RST;
      lvl_mid <= fzc_pkg::MID_SPEED_RST;
      lvl_high <= fzc_pkg::HIGH_SPEED_RST;
      speed_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fzc_pkg::REG_LOW_SPEED:  lvl_low <= cfg_data;
          fzc_pkg::REG_MID_SPEED:  lvl_mid <= cfg_data;
          fzc_pkg::REG_HIGH_SPEED: lvl_high <= cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) speed_q.push_back(predict_speed(s_tdata));
      if (m_tvalid && m_tready) begin
        if (speed_q.size() == 0) begin
          $display("%0t: unexpected result %h/%b", $time, m_tdata, m_tuser);
          fail_count <= fail_count + 1;
        end else begin
          want = speed_q.pop_front();
          if (want.left_speed !== m_tdata[15:0] || want.right_speed !== m_tdata[31:16]
              || want.avoid_mode !== m_tuser) begin
            $display("%0t: expected l=%h r=%h mode=%b, got l=%h r=%h mode=%b", $time,
                     want.left_speed, want.right_speed, want.avoid_mode,
                     m_tdata[15:0], m_tdata[31:16], m_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[sim/tb_top.sv]
module tb_top;

  localparam int LATENCY = 6 + fzc_pkg::FRAC_BITS + 8;
  localparam int STALL_LIMIT = 5000;

  logic        clk, rst;
  logic        s_tvalid, s_tready;
  logic [39:0] s_tdata;
  logic        m_tvalid, m_tready;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  int          fail_count, pending;
  int          idle_pct;     // idle percentage applied to both sides
  bit          hold_sink;    // long receiver hold-off request
  int          quiet_cycles;

  fuzzy_two_motor_speed_controller dut (.*);

  speed_checker u_check (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin
    m_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        m_tready <= 0;
        repeat (300) @(negedge clk);
        hold_sink = 0;
      end
      m_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Watchdog on cycles with no accepted item on either side and no config write.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Pick a sample that lands near a breakpoint or anywhere in range.
  function automatic logic [11:0] pick_dist();
    case ($urandom_range(3))
      0: return $urandom_range(4095);
      1: return $urandom_range(700);
      default: return $urandom_range(250, 650);
    endcase
  endfunction

  // Offer one item; valid stays up after acceptance until the next drive.
  task automatic send(input logic [11:0] d1, input logic [11:0] d2, input logic [11:0] d3);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {4'h0, d3, d2, d1};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drain, let the pipeline flush, then write one level register.
  task automatic write_level(input logic [1:0] idx, input logic [7:0] val);
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_levels(input logic [7:0] lo, input logic [7:0] md, input logic [7:0] hi);
    write_level(fzc_pkg::REG_LOW_SPEED, lo);
    write_level(fzc_pkg::REG_MID_SPEED, md);
    write_level(fzc_pkg::REG_HIGH_SPEED, hi);
  endtask

  initial begin
    logic [11:0] edges[$];
    int wait_cycles;
    edges = '{0, 300, 301, 350, 400, 401, 500, 501, 550, 600, 601, 4095};
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    cfg_we = 0;
    cfg_index = fzc_pkg::REG_LOW_SPEED;
    cfg_data = 0;
    idle_pct = 12;
    hold_sink = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: breakpoints on each sample, both rule bases, all-ones.
    foreach (edges[i]) send(edges[i], edges[(i + 5) % 12], edges[(i + 8) % 12]);
    send(12'hFFF, 12'd100, 12'd900);  // wall-follow
    send(12'd350, 12'd450, 12'd550);
    send(12'd0, 12'd0, 12'd0);
    send(12'd555, 12'd499, 12'd501);  // wall-follow at the edge
    send(12'd555, 12'd500, 12'd501);  // just misses wall-follow

    // Level extremes, then random settings; vary idling across phases.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_levels(8'd0, 8'd0, 8'd0);
        1: set_levels(8'd255, 8'd255, 8'd255);
        2: set_levels(8'd0, 8'd128, 8'd255);
        3: set_levels(8'd255, 8'd1, 8'd0);
        default: set_levels($urandom_range(255), $urandom_range(255), $urandom_range(255));
      endcase
      idle_pct = (phase == 2) ? 0 : 12;   // one stretch with no idling
      if (phase == 3) hold_sink = 1;      // fill the pipe against a stalled sink
      for (int n = 0; n < 220; n++) send(pick_dist(), pick_dist(), pick_dist());
      idle_pct = 12;
    end

    // Sender pause until every result is back, then a short final burst.
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    for (int n = 0; n < 30; n++) send(pick_dist(), pick_dist(), pick_dist());
    s_tvalid <= 0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (LATENCY + 4) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

[sim.f]
src/fzc_pkg.sv
src/fzc_fuzzify.sv
src/fzc_rules.sv
src/fzc_divider.sv
src/fuzzy_two_motor_speed_controller.sv
sim/speed_checker.sv
sim/tb_top.sv
